// ===== src/tvyv_pkg.sv =====
// ----------------------------------------------------------------------------
// tvyv_pkg: shared types, constants and table builders
// Constants for the time-varying yield viscosity datapath. The log2 and exp2
// interpolation tables are generated by constant functions at elaboration.
// ----------------------------------------------------------------------------
package tvyv_pkg;

  localparam int LUT_BITS_DEF = 8;
  localparam int FB = 30;
  localparam logic [22:0] LOG2E_Q22 = 23'd6051102;
  localparam logic [31:0] VSMALL = 32'd1;
  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

  localparam logic [2:0] REG_CONSISTENCY = 3'd0;
  localparam logic [2:0] REG_FLOW_INDEX  = 3'd1;
  localparam logic [2:0] REG_YIELD       = 3'd2;
  localparam logic [2:0] REG_CEILING     = 3'd3;
  localparam logic [2:0] REG_TIME_GROWTH = 3'd4;

  typedef struct packed {
    logic [4:0]  msb;
    logic [29:0] frac;
  } tvyv_norm_t;

  // leading one position and Q.30 mantissa fraction of a nonzero code
  function automatic tvyv_norm_t tvyv_norm(input logic [31:0] x);
    tvyv_norm_t res;
    logic [4:0]  m;
    logic [31:0] y;
    m = 5'd0;
    for (int k = 0; k < 32; k++) begin
      if (x[k]) m = k[4:0];
    end
    if (m == 5'd31) y = x >> 1;
    else y = x << (5'd30 - m);
    res.msb = m;
    res.frac = y[29:0];
    return res;
  endfunction

  function automatic logic [63:0] tvyv_isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r = 64'd0;
    b = 64'd1 << 62;
    vv = v;
    for (int k = 0; k < 32; k++) begin
      if (b > vv) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (vv >= r + b) begin
          vv = vv - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] tvyv_log_entry(input int i, input int lb);
    logic [63:0] y;
    logic [63:0] v;
    int ish;
    ish = FB - lb;
    v = 64'd0;
    y = (64'd1 << FB) + (64'(i) << ish);
    if (i == (1 << lb)) return 32'd1 << FB;
    for (int b = FB - 1; b >= 0; b--) begin
      y = (y * y) >> FB;
      if (y >= (64'd2 << FB)) begin
        v = v | (64'd1 << b);
        y = y >> 1;
      end
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] tvyv_exp_entry(input int i, input int lb);
    logic [63:0] r;
    logic [63:0] cur;
    r = 64'd1 << FB;
    cur = tvyv_isqrt(64'd2 << 60);
    if (i == (1 << lb)) return 32'd2 << FB;
    for (int b = 0; b < lb; b++) begin
      if (b > 0) cur = tvyv_isqrt(cur << FB);
      if (((i >> (lb - 1 - b)) & 1) != 0)
        r = (r * cur + (64'd1 << (FB - 1))) >> FB;
    end
    return r[31:0];
  endfunction

endpackage

// ===== src/time_varying_yield_viscosity.sv =====
// ----------------------------------------------------------------------------
// time_varying_yield_viscosity: Herschel-Bulkley viscosity, time-grown k
// nu = min(ceiling, (tau0 + k*exp(c*t)*sr^n) / max(sr, ulp)), formed in the
// log2 domain with table-interpolated log2/exp2 units and a pipelined divider.
//
//   channel | ports                                 | dir
//   input   | in_valid in_ready in_strain_rate      | in
//           | in_sim_time                           |
//   result  | out_valid out_ready out_viscosity     | out
//           | out_clamped                           |
//   config  | cfg_we cfg_index cfg_data             | in
//
// Throughput is one per cycle while the output is not stalled, set by the fully
// pipelined datapath (7 stages of log/exp math, 33 divider stages, output
// register).
// Reset is synchronous active low and restores the register defaults.
// A stalled output freezes the whole pipeline; bubbles are kept in place.
// ----------------------------------------------------------------------------
module time_varying_yield_viscosity #(
  parameter int LUT_BITS = tvyv_pkg::LUT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_strain_rate,
  input  logic [31:0] in_sim_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_viscosity,
  output logic        out_clamped,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tvyv_pkg::*;

  localparam int TN  = 1 << LUT_BITS;
  localparam int ISH = FB - LUT_BITS;
  localparam int DPW = 34 + ISH;

  // tables
  logic [31:0] log_tab[TN+1];
  logic [31:0] exp_tab[TN+1];
  for (genvar gi = 0; gi <= TN; gi++) begin : g_tab
    assign log_tab[gi] = tvyv_log_entry(gi, LUT_BITS);
    assign exp_tab[gi] = tvyv_exp_entry(gi, LUT_BITS);
  end

  // configuration
  logic [31:0] consistency_r;
  logic [15:0] flow_index_r;
  logic [31:0] yield_stress_r;
  logic [31:0] ceiling_r;
  logic [31:0] time_growth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      consistency_r  <= 32'd65536;
      flow_index_r   <= 16'd4096;
      yield_stress_r <= 32'd0;
      ceiling_r      <= ALL32;
      time_growth_r  <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONSISTENCY: consistency_r  <= cfg_data;
        REG_FLOW_INDEX:  flow_index_r   <= cfg_data[15:0];
        REG_YIELD:       yield_stress_r <= cfg_data;
        REG_CEILING:     ceiling_r      <= cfg_data;
        REG_TIME_GROWTH: time_growth_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage A: normalize, c*t product
  tvyv_norm_t nsr, nk;
  assign nsr = tvyv_norm(in_strain_rate);
  assign nk  = tvyv_norm(consistency_r);

  logic               a_v_r, a_pz_r;
  logic [31:0]        a_sr_r;
  tvyv_norm_t         a_nsr_r, a_nk_r;
  logic signed [64:0] a_ctp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_valid;
    if (adv) begin
      a_pz_r  <= (in_strain_rate != 32'd0) && (consistency_r != 32'd0);
      a_sr_r  <= in_strain_rate;
      a_nsr_r <= nsr;
      a_nk_r  <= nk;
      a_ctp_r <= $signed(time_growth_r) * $signed({1'b0, in_sim_time});
    end
  end

  // stage B: log table lookups and slope products, c*t clamp
  logic [LUT_BITS:0]  b_i0s, b_i1s, b_i0k, b_i1k;
  logic signed [32:0] b_ds, b_dk;
  logic signed [64:0] b_cts;
  logic signed [40:0] b_ct_nxt;
  localparam logic signed [64:0] CT_LIM = 65'sd1 <<< 39;

  assign b_i0s = {1'b0, a_nsr_r.frac[29 -: LUT_BITS]};
  assign b_i1s = b_i0s + 1'b1;
  assign b_i0k = {1'b0, a_nk_r.frac[29 -: LUT_BITS]};
  assign b_i1k = b_i0k + 1'b1;
  assign b_ds  = $signed({1'b0, log_tab[b_i1s]}) - $signed({1'b0, log_tab[b_i0s]});
  assign b_dk  = $signed({1'b0, log_tab[b_i1k]}) - $signed({1'b0, log_tab[b_i0k]});
  assign b_cts = a_ctp_r >>> 10;

  always_comb begin
    if (b_cts > CT_LIM) b_ct_nxt = CT_LIM[40:0];
    else if (b_cts < -CT_LIM) b_ct_nxt = 41'(-CT_LIM);
    else b_ct_nxt = b_cts[40:0];
  end

  logic                  b_v_r, b_pz_r;
  logic [31:0]           b_sr_r;
  logic [4:0]            b_ms_r, b_mk_r;
  logic [31:0]           b_bs_r, b_bk_r;
  logic signed [DPW-1:0] b_dps_r, b_dpk_r;
  logic signed [40:0]    b_ct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
    if (adv) begin
      b_pz_r  <= a_pz_r;
      b_sr_r  <= a_sr_r;
      b_ms_r  <= a_nsr_r.msb;
      b_mk_r  <= a_nk_r.msb;
      b_bs_r  <= log_tab[b_i0s];
      b_bk_r  <= log_tab[b_i0k];
      b_dps_r <= b_ds * $signed({1'b0, a_nsr_r.frac[ISH-1:0]});
      b_dpk_r <= b_dk * $signed({1'b0, a_nk_r.frac[ISH-1:0]});
      b_ct_r  <= b_ct_nxt;
    end
  end

  // stage C: assemble log2 values, split c*t*log2e products
  logic signed [DPW-1:0] c_shs, c_shk;
  logic signed [36:0]    c_lsr_nxt, c_lk_nxt;
  assign c_shs = b_dps_r >>> ISH;
  assign c_shk = b_dpk_r >>> ISH;
  assign c_lsr_nxt = (($signed({32'd0, b_ms_r}) - 37'sd16) <<< FB)
                   + $signed({5'd0, b_bs_r}) + $signed(c_shs[36:0]);
  assign c_lk_nxt  = (($signed({32'd0, b_mk_r}) - 37'sd16) <<< FB)
                   + $signed({5'd0, b_bk_r}) + $signed(c_shk[36:0]);

  logic               c_v_r, c_pz_r;
  logic [31:0]        c_sr_r;
  logic signed [36:0] c_lsr_r, c_lk_r;
  logic signed [44:0] c_ph_r;
  logic [42:0]        c_pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
    if (adv) begin
      c_pz_r  <= b_pz_r;
      c_sr_r  <= b_sr_r;
      c_lsr_r <= c_lsr_nxt;
      c_lk_r  <= c_lk_nxt;
      c_ph_r  <= $signed(b_ct_r[40:20]) * $signed({1'b0, LOG2E_Q22});
      c_pl_r  <= b_ct_r[19:0] * LOG2E_Q22;
    end
  end

  // stage D: n*log2 sr, recombine time exponent
  logic signed [65:0] d_ctl, d_e3s;
  assign d_ctl = (66'(c_ph_r) <<< 20) + $signed({23'd0, c_pl_r});
  assign d_e3s = d_ctl >>> 22;

  logic               d_v_r, d_pz_r;
  logic [31:0]        d_sr_r;
  logic signed [36:0] d_lk_r;
  logic signed [53:0] d_nl_r;
  logic signed [43:0] d_e3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= c_v_r;
    if (adv) begin
      d_pz_r <= c_pz_r;
      d_sr_r <= c_sr_r;
      d_lk_r <= c_lk_r;
      d_nl_r <= $signed({1'b0, flow_index_r}) * c_lsr_r;
      d_e3_r <= d_e3s[43:0];
    end
  end

  // stage E: exponent sum
  logic signed [53:0] e_nls;
  logic signed [45:0] e_sum;
  assign e_nls = d_nl_r >>> 12;
  assign e_sum = 46'(d_lk_r) + 46'(e_nls) + 46'(d_e3_r) + (46'sd16 <<< FB);

  logic               e_v_r, e_pz_r;
  logic [31:0]        e_sr_r;
  logic signed [45:0] e_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (adv) e_v_r <= d_v_r;
    if (adv) begin
      e_pz_r <= d_pz_r;
      e_sr_r <= d_sr_r;
      e_e_r  <= e_sum;
    end
  end

  // stage F: exp2 table lookup
  logic [LUT_BITS:0]  f_i0, f_i1;
  logic signed [32:0] f_d;
  logic               f_big;
  assign f_i0  = {1'b0, e_e_r[29 -: LUT_BITS]};
  assign f_i1  = f_i0 + 1'b1;
  assign f_d   = $signed({1'b0, exp_tab[f_i1]}) - $signed({1'b0, exp_tab[f_i0]});
  assign f_big = !e_e_r[45] && (e_e_r[44:35] != 10'd0);

  logic                  f_v_r, f_pz_r, f_neg_r, f_big_r;
  logic [31:0]           f_sr_r;
  logic [4:0]            f_ip_r;
  logic [31:0]           f_b_r;
  logic signed [DPW-1:0] f_dp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (adv) f_v_r <= e_v_r;
    if (adv) begin
      f_pz_r  <= e_pz_r;
      f_sr_r  <= e_sr_r;
      f_neg_r <= e_e_r[45];
      f_big_r <= f_big;
      f_ip_r  <= e_e_r[34:30];
      f_b_r   <= exp_tab[f_i0];
      f_dp_r  <= f_d * $signed({1'b0, e_e_r[ISH-1:0]});
    end
  end

  // stage G: exp2 scaling, saturation, numerator
  logic signed [DPW-1:0] g_sh;
  logic signed [32:0]    g_ms;
  logic [31:0]           g_m;
  logic [63:0]           g_raw;
  logic [31:0]           g_term;
  logic                  g_sat;
  assign g_sh  = f_dp_r >>> ISH;
  assign g_ms  = $signed({1'b0, f_b_r}) + $signed(g_sh[32:0]);
  assign g_m   = g_ms[32] ? 32'd0 : g_ms[31:0];
  assign g_raw = ({32'd0, g_m} << f_ip_r) >> FB;

  always_comb begin
    g_term = 32'd0;
    g_sat  = 1'b0;
    if (f_pz_r && !f_neg_r) begin
      if (f_big_r || (g_raw[63:32] != 32'd0)) begin
        g_term = ALL32;
        g_sat  = 1'b1;
      end else begin
        g_term = g_raw[31:0];
      end
    end
  end

  logic        g_v_r, g_sat_r;
  logic [32:0] g_num_r;
  logic [31:0] g_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (adv) g_v_r <= f_v_r;
    if (adv) begin
      g_sat_r <= g_sat;
      g_num_r <= {1'b0, yield_stress_r} + {1'b0, g_term};
      g_den_r <= (f_sr_r != 32'd0) ? f_sr_r : VSMALL;
    end
  end

  // divider
  logic        dv_v, dv_sat;
  logic [31:0] dv_q;

  tvyv_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_v   (g_v_r),
    .num    (g_num_r),
    .den    (g_den_r),
    .sat_in (g_sat_r),
    .out_v  (dv_v),
    .q      (dv_q),
    .sat    (dv_sat)
  );

  // ceiling and output register
  logic [31:0] visc_nxt;
  logic        clamp_nxt;
  always_comb begin
    visc_nxt  = dv_q;
    clamp_nxt = dv_sat;
    if (dv_q > ceiling_r) begin
      visc_nxt  = ceiling_r;
      clamp_nxt = 1'b1;
    end
  end

  logic [31:0] visc_r;
  logic        clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_v;
    if (adv) begin
      visc_r  <= visc_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_viscosity = visc_r;
  assign out_clamped   = clamp_r;

endmodule

// ===== src/tvyv_div.sv =====
// ----------------------------------------------------------------------------
// tvyv_div: pipelined restoring divider
// Computes (num << 16) / den in 33 stages: an input stage that flags overflow,
// then one quotient bit per stage. Quotients of 2^32 and above are flagged as saturated.
// ----------------------------------------------------------------------------
module tvyv_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [32:0] num,
  input  logic [31:0] den,
  input  logic        sat_in,
  output logic        out_v,
  output logic [31:0] q,
  output logic        sat
);
  import tvyv_pkg::*;

  localparam int NS = 32;

  logic        v_r   [NS+1];
  logic [31:0] rem_r [NS+1];
  logic [31:0] bits_r[NS+1];
  logic [31:0] q_r   [NS+1];
  logic [31:0] den_r [NS+1];
  logic        sat_r [NS+1];

  logic ovf;
  assign ovf = ({15'd0, num[32:16]} >= den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
    if (en) begin
      rem_r[0]  <= ovf ? 32'd0 : {15'd0, num[32:16]};
      bits_r[0] <= {num[15:0], 16'd0};
      q_r[0]    <= 32'd0;
      den_r[0]  <= den;
      sat_r[0]  <= sat_in | ovf;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;
    assign trial = {rem_r[s], bits_r[s][31]};
    assign ge    = trial >= {1'b0, den_r[s]};
    assign diff  = trial - {1'b0, den_r[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
      if (en) begin
        rem_r[s+1]  <= ge ? diff[31:0] : trial[31:0];
        bits_r[s+1] <= {bits_r[s][30:0], 1'b0};
        q_r[s+1]    <= {q_r[s][30:0], ge};
        den_r[s+1]  <= den_r[s];
        sat_r[s+1]  <= sat_r[s];
      end
    end
  end

  assign out_v = v_r[NS];
  assign q     = sat_r[NS] ? ALL32 : q_r[NS];
  assign sat   = sat_r[NS];

endmodule
